>>> rtl/png_stored_stream_writer_defines.svh
// Assertion macros used by the PNG stream writer checker.
`ifndef PNG_STORED_STREAM_WRITER_DEFINES_SVH
`define PNG_STORED_STREAM_WRITER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PNGSW_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pngsw same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PNGSW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pngsw next-cycle check failed");

`endif

>>> rtl/pngsw_pkg.sv
// Shared types, constants and the CRC-32 byte step for the PNG stream writer.
`timescale 1ns / 1ps
package pngsw_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES   = 32'hFFFFFFFF;
    localparam logic [31:0] IEND_CRC   = 32'hAE426082;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [15:0] BLOCK_MAX  = 16'hFFFF;
    localparam logic [2:0]  ADDR_WIDTH  = 3'd0;
    localparam logic [2:0]  ADDR_HEIGHT = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
        logic       sor;
        logic       eof;
    } pngsw_item_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_HDR   = 6'b000010,
        ST_BLK   = 6'b000100,
        ST_FILT  = 6'b001000,
        ST_PIX   = 6'b010000,
        ST_TRAIL = 6'b100000
    } pngsw_state_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'b0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
        end
        return r;
    endfunction

endpackage

>>> rtl/pngsw_queue.sv
// Short word queue between the classifying front and the emitting back.
`timescale 1ns / 1ps
module pngsw_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pngsw_pkg::pngsw_item_t push_item,
    input  logic                  pop,
    output logic                  full,
    output logic                  nonempty,
    output pngsw_pkg::pngsw_item_t head
);
    localparam int DEPTH = 4;

    pngsw_pkg::pngsw_item_t mem [DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    assign full     = (count_reg == 3'(DEPTH));
    assign nonempty = (count_reg != 3'd0);
    assign head     = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 3'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end
endmodule

>>> rtl/pngsw_front.sv
// Input side: accepts pixel words and marks file start, row start and file end.
`timescale 1ns / 1ps
module pngsw_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             pixel_byte,
    input  logic [14:0]            width,
    input  logic [14:0]            height,
    input  logic                   q_full,
    output logic                   push,
    output pngsw_pkg::pngsw_item_t push_item,
    output logic                   busy
);
    logic        in_file_reg;
    logic [16:0] pos_reg;
    logic [14:0] row_reg;
    logic [16:0] last_pos;
    logic        eol;
    logic        eof;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign busy     = in_file_reg;
    assign last_pos = {width, 2'b00} - 17'd1;
    assign eol      = (pos_reg == last_pos);
    assign eof      = eol && (row_reg == height - 15'd1);

    always_comb
    begin
        push_item.data = pixel_byte;
        push_item.sof  = !in_file_reg;
        push_item.sor  = (pos_reg == 17'd0);
        push_item.eof  = eof;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_file_reg <= 1'b0;
            pos_reg     <= '0;
            row_reg     <= '0;
        end
        else if (push)
        begin
            if (eof)
            begin
                in_file_reg <= 1'b0;
                pos_reg     <= '0;
                row_reg     <= '0;
            end
            else
            begin
                in_file_reg <= 1'b1;
                pos_reg     <= eol ? 17'd0 : pos_reg + 17'd1;
                row_reg     <= eol ? row_reg + 15'd1 : row_reg;
            end
        end
    end
endmodule

>>> rtl/pngsw_back.sv
// Output side: emits header, stored block framing, raw bytes and trailer.
`timescale 1ns / 1ps
module pngsw_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [14:0]            width,
    input  logic [14:0]            height,
    input  logic                   q_valid,
    input  pngsw_pkg::pngsw_item_t q_item,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_byte,
    output logic                   last_of_run,
    output logic                   end_of_file
);
    localparam logic [5:0] HDR_LAST = 6'd42;
    localparam logic [5:0] BLK_LAST = 6'd4;
    localparam logic [5:0] TRL_LAST = 6'd19;

    pngsw_pkg::pngsw_state_t state_reg, state_next;
    logic [5:0]              idx_reg, idx_next;
    pngsw_pkg::pngsw_item_t  item_reg, item_next;
    logic                    tofilt_reg, tofilt_next;
    logic [15:0] fill_reg;
    logic [31:0] left_reg;
    logic [31:0] crc_reg;
    logic [15:0] alo_reg;
    logic [15:0] ahi_reg;
    logic [31:0] raw_reg;
    logic [17:0] blocks_reg;
    logic [31:0] len_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        last_reg;
    logic        eof_reg;

    logic        adv;
    logic [7:0]  gen_byte;
    logic        crc_en;
    logic        crc_init;
    logic        raw_en;
    logic        phase_end;
    logic        last_run;
    logic        last_file;
    logic [31:0] crc_nx;
    logic [31:0] crc_inv;
    logic [15:0] blk_size;
    logic [15:0] blk_inv;
    logic        blk_final;
    logic [7:0]  raw_b;
    logic [16:0] s1;
    logic [15:0] lo_n;
    logic [16:0] s2;
    logic [15:0] hi_n;
    logic [15:0] fill_inc;
    logic [15:0] fill_nx;
    logic [15:0] fill_after;
    logic        item_done;
    logic [32:0] div_y;
    logic [17:0] div_r;
    logic [17:0] div_q;

    assign adv       = (state_reg != pngsw_pkg::ST_IDLE) && (!out_valid_reg || !out_stall);
    assign crc_inv   = ~crc_reg;
    assign blk_final = (left_reg <= 32'(pngsw_pkg::BLOCK_MAX));
    assign blk_size  = blk_final ? left_reg[15:0] : pngsw_pkg::BLOCK_MAX;
    assign blk_inv   = ~blk_size;
    assign raw_b     = (state_reg == pngsw_pkg::ST_FILT) ? 8'h00 : item_reg.data;
    assign s1        = 17'(alo_reg) + 17'(raw_b);
    assign lo_n      = (s1 >= pngsw_pkg::ADLER_MOD) ? 16'(s1 - pngsw_pkg::ADLER_MOD)
                                                    : s1[15:0];
    assign s2        = 17'(ahi_reg) + 17'(lo_n);
    assign hi_n      = (s2 >= pngsw_pkg::ADLER_MOD) ? 16'(s2 - pngsw_pkg::ADLER_MOD)
                                                    : s2[15:0];
    assign fill_inc  = fill_reg + 16'd1;
    assign fill_nx   = (fill_inc == pngsw_pkg::BLOCK_MAX) ? 16'd0 : fill_inc;
    assign fill_after = (adv && raw_en) ? fill_nx : fill_reg;
    assign crc_nx    = pngsw_pkg::crc_byte(crc_init ? pngsw_pkg::CRC_ONES : crc_reg, gen_byte);

    always_comb
    begin
        gen_byte  = 8'h00;
        crc_en    = 1'b0;
        crc_init  = 1'b0;
        raw_en    = 1'b0;
        phase_end = 1'b0;
        last_run  = 1'b0;
        last_file = 1'b0;
        unique case (state_reg)
            pngsw_pkg::ST_HDR:
            begin
                phase_end = (idx_reg == HDR_LAST);
                crc_en    = (idx_reg >= 6'd12 && idx_reg <= 6'd28) || idx_reg >= 6'd37;
                crc_init  = (idx_reg == 6'd12) || (idx_reg == 6'd37);
                case (idx_reg)
                    6'd0:  gen_byte = 8'h89;
                    6'd1:  gen_byte = 8'h50;
                    6'd2:  gen_byte = 8'h4E;
                    6'd3:  gen_byte = 8'h47;
                    6'd4:  gen_byte = 8'h0D;
                    6'd5:  gen_byte = 8'h0A;
                    6'd6:  gen_byte = 8'h1A;
                    6'd7:  gen_byte = 8'h0A;
                    6'd11: gen_byte = 8'h0D;
                    6'd12: gen_byte = 8'h49;
                    6'd13: gen_byte = 8'h48;
                    6'd14: gen_byte = 8'h44;
                    6'd15: gen_byte = 8'h52;
                    6'd18: gen_byte = {1'b0, width[14:8]};
                    6'd19: gen_byte = width[7:0];
                    6'd22: gen_byte = {1'b0, height[14:8]};
                    6'd23: gen_byte = height[7:0];
                    6'd24: gen_byte = 8'h08;
                    6'd25: gen_byte = 8'h06;
                    6'd29: gen_byte = crc_inv[31:24];
                    6'd30: gen_byte = crc_inv[23:16];
                    6'd31: gen_byte = crc_inv[15:8];
                    6'd32: gen_byte = crc_inv[7:0];
                    6'd33: gen_byte = len_reg[31:24];
                    6'd34: gen_byte = len_reg[23:16];
                    6'd35: gen_byte = len_reg[15:8];
                    6'd36: gen_byte = len_reg[7:0];
                    6'd37: gen_byte = 8'h49;
                    6'd38: gen_byte = 8'h44;
                    6'd39: gen_byte = 8'h41;
                    6'd40: gen_byte = 8'h54;
                    6'd41: gen_byte = 8'h78;
                    6'd42: gen_byte = 8'h01;
                    default: gen_byte = 8'h00;
                endcase
            end
            pngsw_pkg::ST_BLK:
            begin
                phase_end = (idx_reg == BLK_LAST);
                crc_en    = 1'b1;
                case (idx_reg)
                    6'd0:    gen_byte = {7'b0, blk_final};
                    6'd1:    gen_byte = blk_size[7:0];
                    6'd2:    gen_byte = blk_size[15:8];
                    6'd3:    gen_byte = blk_inv[7:0];
                    default: gen_byte = blk_inv[15:8];
                endcase
            end
            pngsw_pkg::ST_FILT, pngsw_pkg::ST_PIX:
            begin
                phase_end = 1'b1;
                crc_en    = 1'b1;
                raw_en    = 1'b1;
                gen_byte  = raw_b;
                last_run  = (state_reg == pngsw_pkg::ST_PIX) && !item_reg.eof;
            end
            pngsw_pkg::ST_TRAIL:
            begin
                phase_end = (idx_reg == TRL_LAST);
                last_run  = phase_end;
                last_file = phase_end;
                crc_en    = (idx_reg <= 6'd3);
                case (idx_reg)
                    6'd0:  gen_byte = ahi_reg[15:8];
                    6'd1:  gen_byte = ahi_reg[7:0];
                    6'd2:  gen_byte = alo_reg[15:8];
                    6'd3:  gen_byte = alo_reg[7:0];
                    6'd4:  gen_byte = crc_inv[31:24];
                    6'd5:  gen_byte = crc_inv[23:16];
                    6'd6:  gen_byte = crc_inv[15:8];
                    6'd7:  gen_byte = crc_inv[7:0];
                    6'd12: gen_byte = 8'h49;
                    6'd13: gen_byte = 8'h45;
                    6'd14: gen_byte = 8'h4E;
                    6'd15: gen_byte = 8'h44;
                    6'd16: gen_byte = pngsw_pkg::IEND_CRC[31:24];
                    6'd17: gen_byte = pngsw_pkg::IEND_CRC[23:16];
                    6'd18: gen_byte = pngsw_pkg::IEND_CRC[15:8];
                    6'd19: gen_byte = pngsw_pkg::IEND_CRC[7:0];
                    default: gen_byte = 8'h00;
                endcase
            end
            pngsw_pkg::ST_IDLE:
            begin
                gen_byte = 8'h00;
            end
            default:
            begin
                gen_byte = 8'h00;
            end
        endcase
    end

    assign item_done = adv && phase_end &&
                       (((state_reg == pngsw_pkg::ST_PIX) && !item_reg.eof) ||
                        (state_reg == pngsw_pkg::ST_TRAIL));
    assign pop = q_valid && ((state_reg == pngsw_pkg::ST_IDLE) || item_done);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        tofilt_next = tofilt_reg;
        item_next   = item_reg;
        if (adv)
        begin
            if (!phase_end)
            begin
                idx_next = idx_reg + 6'd1;
            end
            else
            begin
                idx_next = 6'd0;
                priority case (1'b1)
                    state_reg == pngsw_pkg::ST_HDR:
                    begin
                        tofilt_next = item_reg.sor;
                        if (fill_after == 16'd0)
                        begin
                            state_next = pngsw_pkg::ST_BLK;
                        end
                        else
                        begin
                            state_next = item_reg.sor ? pngsw_pkg::ST_FILT : pngsw_pkg::ST_PIX;
                        end
                    end
                    state_reg == pngsw_pkg::ST_BLK:
                    begin
                        state_next = tofilt_reg ? pngsw_pkg::ST_FILT : pngsw_pkg::ST_PIX;
                    end
                    state_reg == pngsw_pkg::ST_FILT:
                    begin
                        tofilt_next = 1'b0;
                        state_next  = (fill_after == 16'd0) ? pngsw_pkg::ST_BLK
                                                            : pngsw_pkg::ST_PIX;
                    end
                    state_reg == pngsw_pkg::ST_PIX:
                    begin
                        state_next = item_reg.eof ? pngsw_pkg::ST_TRAIL : pngsw_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        state_next = pngsw_pkg::ST_IDLE;
                    end
                endcase
            end
        end
        if (pop)
        begin
            item_next   = q_item;
            idx_next    = 6'd0;
            tofilt_next = q_item.sor;
            if (q_item.sof)
            begin
                state_next = pngsw_pkg::ST_HDR;
            end
            else if (fill_after == 16'd0)
            begin
                state_next = pngsw_pkg::ST_BLK;
            end
            else
            begin
                state_next = q_item.sor ? pngsw_pkg::ST_FILT : pngsw_pkg::ST_PIX;
            end
        end
    end

    always_comb
    begin
        div_y = {1'b0, raw_reg} + 33'd65534;
        div_q = 18'(div_y[32:16]);
        div_r = 18'(div_y[15:0]) + 18'(div_y[32:16]);
        for (int k = 0; k < 3; k++)
        begin
            if (div_r >= 18'(pngsw_pkg::BLOCK_MAX))
            begin
                div_r = div_r - 18'(pngsw_pkg::BLOCK_MAX);
                div_q = div_q + 18'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg    <= {17'b0, height} * {15'b0, width, 2'b01};
        blocks_reg <= div_q;
        len_reg    <= raw_reg + 32'd6 + {12'b0, blocks_reg, 2'b00} + {14'b0, blocks_reg};
        item_reg   <= item_next;
        if (adv)
        begin
            out_byte_reg <= gen_byte;
            last_reg     <= last_run;
            eof_reg      <= last_file;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pngsw_pkg::ST_IDLE;
            idx_reg       <= '0;
            tofilt_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
            left_reg      <= '0;
            crc_reg       <= pngsw_pkg::CRC_ONES;
            alo_reg       <= 16'd1;
            ahi_reg       <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            tofilt_reg <= tofilt_next;
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (adv && crc_en)
            begin
                crc_reg <= crc_nx;
            end
            if (adv && state_reg == pngsw_pkg::ST_HDR && idx_reg == 6'd0)
            begin
                fill_reg <= '0;
                alo_reg  <= 16'd1;
                ahi_reg  <= '0;
            end
            if (adv && state_reg == pngsw_pkg::ST_HDR && idx_reg == 6'd33)
            begin
                left_reg <= raw_reg;
            end
            if (adv && raw_en)
            begin
                fill_reg <= fill_nx;
                alo_reg  <= lo_n;
                ahi_reg  <= hi_n;
                left_reg <= left_reg - 32'd1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign end_of_file = eof_reg;
endmodule

>>> rtl/png_stored_stream_writer.sv
// A word's first byte passes the queue, then the back part's state and output byte registers.
// Throughput: one byte per cycle unless stalled, limited by the single emitting back sequencer.
// A word emits 1 byte, plus 43 header bytes at file start, 1 filter byte at row start,
// 5 framing bytes per stored block and 20 trailer bytes at file end.
// A 4-word queue lets input words flow while the back part emits headers and trailers.
// Reset clears all control state and sets width and height to 1; no clearing pass is needed.
`timescale 1ns / 1ps
module png_stored_stream_writer
#(
    parameter int MAX_SIDE = 16384
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pixel_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        end_of_file
);
    logic [14:0] width_reg;
    logic [14:0] height_reg;
    logic [14:0] wval;
    logic [14:0] clamped;
    logic        busy;
    logic        q_full;
    logic        q_nonempty;
    logic        push;
    logic        pop;
    pngsw_pkg::pngsw_item_t push_item;
    pngsw_pkg::pngsw_item_t q_head;

    assign pready = 1'b1;
    assign wval   = pwdata[14:0];

    always_comb
    begin
        if (wval == 15'd0)
        begin
            clamped = 15'd1;
        end
        else if (32'(wval) > 32'(MAX_SIDE))
        begin
            clamped = 15'(MAX_SIDE);
        end
        else
        begin
            clamped = wval;
        end
    end

    always_comb
    begin
        case (paddr)
            pngsw_pkg::ADDR_WIDTH:  prdata = {17'b0, width_reg};
            pngsw_pkg::ADDR_HEIGHT: prdata = {17'b0, height_reg};
            default:                prdata = 32'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 15'd1;
            height_reg <= 15'd1;
        end
        else if (psel && penable && pwrite && !busy)
        begin
            if (paddr == pngsw_pkg::ADDR_WIDTH)
            begin
                width_reg <= clamped;
            end
            else if (paddr == pngsw_pkg::ADDR_HEIGHT)
            begin
                height_reg <= clamped;
            end
        end
    end

    pngsw_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_byte (pixel_byte),
        .width      (width_reg),
        .height     (height_reg),
        .q_full     (q_full),
        .push       (push),
        .push_item  (push_item),
        .busy       (busy)
    );

    pngsw_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .nonempty  (q_nonempty),
        .head      (q_head)
    );

    pngsw_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .width       (width_reg),
        .height      (height_reg),
        .q_valid     (q_nonempty),
        .q_item      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .end_of_file (end_of_file)
    );
endmodule

>>> rtl/pngsw_checker.sv
// Port-level checker for the PNG stream writer and its bind statement.
`timescale 1ns / 1ps
`include "png_stored_stream_writer_defines.svh"
module pngsw_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       end_of_file
);
    `PNGSW_ASSERT_IMPLY(a_eof_ends_run, out_valid && end_of_file, last_of_run)
    `PNGSW_ASSERT_IMPLY(a_eof_crc_tail, out_valid && end_of_file, out_byte == 8'h82)
    `PNGSW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte))
endmodule

bind png_stored_stream_writer pngsw_checker u_pngsw_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .end_of_file (end_of_file)
);
